[rtl/core/irp_pkg.sv]
// ----------------------------------------------------------------------------
// irp_pkg
// Shared widths and the command and status bundles that pass between the
// isotonic regression controller and its datapath.
// ----------------------------------------------------------------------------
package irp_pkg;

  localparam int MAX_LEN   = 64;
  localparam int SAMPLE_W  = 32;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SUM_W     = SAMPLE_W + IDX_W + 2;
  localparam int PROD_W    = SUM_W + CNT_W + 1;
  localparam int DIV_STEPS = SUM_W;
  localparam int ITER_W    = $clog2(DIV_STEPS);

  // Command strobes from the controller; several may be set together.
  typedef struct packed {
    logic load;
    logic pool_start;
    logic rd_cur;
    logic take_cur;
    logic rd_link;
    logic take_p;
    logic mul;
    logic merge;
    logic wr_head;
    logic wr_tail;
    logic next_j;
    logic em_start;
    logic em_rd;
    logic div_load;
    logic div_step;
    logic out_next;
    logic clear;
  } irp_cmd_t;

  // Status flags from the datapath.
  typedef struct packed {
    logic h_zero;
    logic p_ge_h;
    logic le;
    logic last_j;
    logic div_done;
    logic blk_done;
    logic vec_done;
  } irp_stat_t;

endpackage

[rtl/core/isotonic_regression_pav.sv]
// ----------------------------------------------------------------------------
// isotonic_regression_pav
// Non-increasing isotonic fit of a sample vector by pool-adjacent-violators.
// ----------------------------------------------------------------------------
// Usage: samples enter on the input channel (sample, last, in_valid,
// in_ready), one transfer per cycle while the block is idle. Up to 64 samples
// are held; further samples are dropped and raise truncated on every result.
// A transfer with last set starts pooling, and in_ready stays low until the
// whole vector has been sent out. The output channel (fitted, end_of_vector,
// truncated, out_valid, out_ready) gives one fitted value per held position,
// in order; end_of_vector marks the final one.
// Pooling reads each sample and makes it the active block, which then merges
// with the block before it while that block's mean is not greater, using the
// cross-multiply compare. Emission runs a serial divide per block (one
// quotient bit a cycle) and then sends one result per position of the block.
// All reads share the single memory read port. A stalled receiver simply
// holds the current result; nothing is lost. Reset returns the block to idle
// with an empty vector.
// ----------------------------------------------------------------------------
module isotonic_regression_pav
  import irp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  input  logic                in_valid,
  output logic                in_ready,
  output logic [SAMPLE_W-1:0] fitted,
  output logic                end_of_vector,
  output logic                truncated,
  output logic                out_valid,
  input  logic                out_ready
);

  irp_cmd_t  cmd;
  irp_stat_t stat;

  irp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  irp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .sample        (sample),
    .fitted        (fitted),
    .end_of_vector (end_of_vector),
    .truncated     (truncated)
  );

endmodule

[rtl/core/irp_datapath.sv]
// ----------------------------------------------------------------------------
// irp_datapath
// Block memories, the active pooling block, the cross-multiply compare and a
// bit-serial divider for the block means.
// ----------------------------------------------------------------------------
module irp_datapath
  import irp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  irp_cmd_t            cmd,
  output irp_stat_t           stat,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SAMPLE_W-1:0] fitted,
  output logic                end_of_vector,
  output logic                truncated
);

  // Block memories.
  logic signed [SUM_W-1:0] mem_sum  [MAX_LEN];
  logic [CNT_W-1:0]        mem_cnt  [MAX_LEN];
  logic [IDX_W-1:0]        mem_link [MAX_LEN];

  logic signed [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0]        rd_cnt;
  logic [IDX_W-1:0]        rd_link;

  logic [CNT_W-1:0]        n;
  logic                    ovf;
  logic [IDX_W-1:0]        j;
  logic [IDX_W-1:0]        h;
  logic [IDX_W-1:0]        p;
  logic [IDX_W-1:0]        k;
  logic [IDX_W-1:0]        blk_end;
  logic signed [SUM_W-1:0] cur_sum;
  logic [CNT_W-1:0]        cur_cnt;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;

  logic [SUM_W-1:0]        dvd;
  logic [CNT_W:0]          rem;
  logic [CNT_W-1:0]        dvs;
  logic                    neg;
  logic [ITER_W-1:0]       iter;

  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic                    full;
  logic [CNT_W:0]          trial;
  logic [SUM_W-1:0]        quot;

  assign full = (n == CNT_W'(MAX_LEN));

  // Read address selection for the shared read port.
  always_comb begin
    rd_addr = h;
    if (cmd.rd_cur) begin
      rd_addr = j;
    end else if (cmd.rd_link) begin
      rd_addr = h - IDX_W'(1);
    end else if (cmd.take_p) begin
      rd_addr = rd_link;
    end
  end

  // Write address selection.
  always_comb begin
    wr_addr = h;
    if (cmd.load) begin
      wr_addr = n[IDX_W-1:0];
    end else if (cmd.wr_tail) begin
      wr_addr = j;
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem_sum[wr_addr] <= SUM_W'($signed(sample));
    end
    if (cmd.wr_head) begin
      mem_sum[wr_addr]  <= cur_sum;
      mem_cnt[wr_addr]  <= cur_cnt;
      mem_link[wr_addr] <= j;
    end
    if (cmd.wr_tail) begin
      mem_link[wr_addr] <= h;
    end
    if (cmd.rd_cur || cmd.rd_link || cmd.take_p || cmd.em_rd) begin
      rd_sum  <= mem_sum[rd_addr];
      rd_cnt  <= mem_cnt[rd_addr];
      rd_link <= mem_link[rd_addr];
    end
  end

  // Load count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      n   <= '0;
      ovf <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        n <= n + CNT_W'(1);
      end
    end
  end

  // Pooling and emission registers.
  always_ff @(posedge clk) begin
    if (cmd.pool_start) begin
      j <= '0;
    end else if (cmd.next_j) begin
      j <= j + IDX_W'(1);
    end
    if (cmd.take_cur) begin
      cur_sum <= rd_sum;
      cur_cnt <= CNT_W'(1);
      h       <= j;
    end else if (cmd.merge) begin
      cur_sum <= cur_sum + rd_sum;
      cur_cnt <= cur_cnt + rd_cnt;
      h       <= p;
    end else if (cmd.em_start) begin
      h <= '0;
    end else if (cmd.out_next && k == blk_end) begin
      h <= blk_end + IDX_W'(1);
    end
    if (cmd.take_p) begin
      p <= rd_link;
    end
    if (cmd.mul) begin
      prod_a <= PROD_W'(rd_sum) * PROD_W'($signed({1'b0, cur_cnt}));
      prod_b <= PROD_W'(cur_sum) * PROD_W'($signed({1'b0, rd_cnt}));
    end
    if (cmd.div_load) begin
      k       <= h;
      blk_end <= rd_link;
    end else if (cmd.out_next) begin
      k <= k + IDX_W'(1);
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign trial = {rem[CNT_W-1:0], dvd[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg  <= rd_sum[SUM_W-1];
      dvd  <= rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
      dvs  <= rd_cnt;
      rem  <= '0;
      iter <= '0;
    end else if (cmd.div_step) begin
      iter <= iter + ITER_W'(1);
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        dvd <= {dvd[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        dvd <= {dvd[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot          = neg ? (~dvd + SUM_W'(1)) : dvd;
  assign fitted        = quot[SAMPLE_W-1:0];
  assign end_of_vector = ({1'b0, k} == n - CNT_W'(1));
  assign truncated     = ovf;

  // Status back to the controller.
  always_comb begin
    stat.h_zero   = (h == '0);
    stat.p_ge_h   = (rd_link >= h);
    stat.le       = (prod_a <= prod_b);
    stat.last_j   = ({1'b0, j} == n - CNT_W'(1));
    stat.div_done = (iter == ITER_W'(DIV_STEPS - 1));
    stat.blk_done = (k == blk_end);
    stat.vec_done = ({1'b0, blk_end} == n - CNT_W'(1));
  end

endmodule

[rtl/core/irp_ctrl.sv]
// ----------------------------------------------------------------------------
// irp_ctrl
// Sequencer for loading, pooling with backtracking, and emission.
// ----------------------------------------------------------------------------
module irp_ctrl
  import irp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      last,
  output logic      out_valid,
  input  logic      out_ready,
  input  irp_stat_t stat,
  output irp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LD, S_CUR, S_CHECK, S_P, S_MUL, S_CMP, S_WR1, S_WR2,
    E_RD, E_LOAD, E_DIV, E_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == E_OUT);

  // Commands and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last) begin
            cmd.pool_start = 1'b1;
            state_next     = S_LD;
          end
        end
      end
      S_LD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_CUR;
      end
      S_CUR: begin
        cmd.take_cur = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (stat.h_zero) begin
          state_next = S_WR1;
        end else begin
          cmd.rd_link = 1'b1;
          state_next  = S_P;
        end
      end
      S_P: begin
        if (stat.p_ge_h) begin
          state_next = S_WR1;
        end else begin
          cmd.take_p = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.le) begin
          cmd.merge  = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_WR1;
        end
      end
      S_WR1: begin
        cmd.wr_head = 1'b1;
        state_next  = S_WR2;
      end
      S_WR2: begin
        cmd.wr_tail = 1'b1;
        if (stat.last_j) begin
          cmd.em_start = 1'b1;
          state_next   = E_RD;
        end else begin
          cmd.next_j = 1'b1;
          state_next = S_LD;
        end
      end
      E_RD: begin
        cmd.em_rd  = 1'b1;
        state_next = E_LOAD;
      end
      E_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = E_DIV;
      end
      E_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = E_OUT;
        end
      end
      E_OUT: begin
        if (out_ready) begin
          cmd.out_next = 1'b1;
          if (stat.blk_done && stat.vec_done) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else if (stat.blk_done) begin
            state_next = E_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sim/tb_isotonic_regression_pav.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_isotonic_regression_pav
// Self-checking bench for the non-increasing isotonic fit. Vectors of random
// and shaped samples are sent in; a local pooling predictor computes the
// fitted values, and every output transfer is compared with them in order.
// ----------------------------------------------------------------------------
module tb_isotonic_regression_pav;
  import irp_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                is_last;
  } sample_item_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                eov;
    logic                trunc;
  } fit_item_t;

  logic                clk;
  logic                rst;
  logic [SAMPLE_W-1:0] sample;
  logic                last;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] fitted;
  logic                end_of_vector;
  logic                truncated;
  logic                out_valid;
  logic                out_ready;

  sample_item_t pending_samples[$];
  fit_item_t    expected_fits[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  int           fail_count;
  bit           stimulus_done;
  bit           in_ready_seen;

  // Predictor state.
  longint      vec_val[MAX_LEN];
  longint      blk_sum[MAX_LEN];
  longint      blk_cnt[MAX_LEN];
  int          blk_link[MAX_LEN];
  int          held_count;
  bit          dropped;

  isotonic_regression_pav u_dut (
    .clk(clk), .rst(rst), .sample(sample), .last(last), .in_valid(in_valid),
    .in_ready(in_ready), .fitted(fitted), .end_of_vector(end_of_vector),
    .truncated(truncated), .out_valid(out_valid), .out_ready(out_ready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Exact test of mean(a) <= mean(b) via floor quotient and remainder.
  function automatic bit mean_at_most(longint sa, longint ca, longint sb, longint cb);
    longint qa, ra, qb, rb;
    qa = sa / ca;
    ra = sa % ca;
    if (ra < 0) begin
      ra += ca;
      qa -= 1;
    end
    qb = sb / cb;
    rb = sb % cb;
    if (rb < 0) begin
      rb += cb;
      qb -= 1;
    end
    if (qa != qb) return qa < qb;
    return ra * cb <= rb * ca;
  endfunction

  // Pools the held vector and queues one fitted value per position.
  task automatic predict_fit();
    int n, h, p, tail, k;
    longint mean;
    n = held_count;
    for (int j = 0; j < n; j++) begin
      blk_sum[j] = vec_val[j];
      blk_cnt[j] = 1;
      blk_link[j] = j;
      h = j;
      while (h > 0) begin
        p = blk_link[h-1];
        if (p >= h) break;
        if (!mean_at_most(blk_sum[p], blk_cnt[p], blk_sum[h], blk_cnt[h])) break;
        tail = blk_link[h];
        blk_sum[p] += blk_sum[h];
        blk_cnt[p] += blk_cnt[h];
        blk_link[p] = tail;
        blk_link[tail] = p;
        h = p;
      end
    end
    h = 0;
    while (h < n) begin
      tail = blk_link[h];
      mean = blk_sum[h] / blk_cnt[h];
      for (k = h; k <= tail; k++)
        expected_fits.push_back('{mean[SAMPLE_W-1:0], k + 1 == n, dropped});
      h = tail + 1;
    end
    held_count = 0;
    dropped = 0;
  endtask

  task automatic add_sample(logic [SAMPLE_W-1:0] v, logic is_last);
    pending_samples.push_back('{v, is_last});
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 7) - 3;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // Driver: presents queued samples, changing only at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sample   <= pending_samples[0].value;
        last     <= pending_samples[0].is_last;
        in_valid <= 1'b1;
        void'(pending_samples.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Input transfers feed the predictor at the rising edge.
  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (!rst && in_valid && in_ready) begin
      in_ready_seen <= 1'b1;
      if (held_count < MAX_LEN) begin
        vec_val[held_count] = longint'($signed(sample));
        held_count++;
      end else begin
        dropped = 1;
      end
      if (last) predict_fit();
    end
  end

  // Monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk) begin
    fit_item_t exp_fit;
    if (!rst && out_valid && out_ready) begin
      if (expected_fits.size() == 0) begin
        $error("unexpected fitted=%0d", $signed(fitted));
        fail_count++;
      end else begin
        exp_fit = expected_fits.pop_front();
        if (fitted !== exp_fit.value) begin
          $error("fitted expected %0d actual %0d", $signed(exp_fit.value), $signed(fitted));
          fail_count++;
        end
        if (end_of_vector !== exp_fit.eov) begin
          $error("end_of_vector expected %0b actual %0b", exp_fit.eov, end_of_vector);
          fail_count++;
        end
        if (truncated !== exp_fit.trunc) begin
          $error("truncated expected %0b actual %0b", exp_fit.trunc, truncated);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid || expected_fits.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int len, mode;
    rst = 1'b1;
    sample = '0;
    last = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    held_count = 0;
    dropped = 0;
    fail_count = 0;
    send_idle_pct = 36;
    recv_idle_pct = 45;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: single sample, extremes, equal means, rising run, overflow.
    add_sample(32'h7fff_ffff, 1'b1);
    add_sample(32'h8000_0000, 1'b1);
    add_sample(32'h8000_0000, 1'b0);
    add_sample(32'h7fff_ffff, 1'b1);
    add_sample(32'h7fff_ffff, 1'b0);
    add_sample(32'h8000_0000, 1'b1);
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(5, 1'b1);
    add_sample(-7, 1'b0);
    add_sample(-2, 1'b0);
    add_sample(0, 1'b0);
    add_sample(4, 1'b1);
    add_sample(3, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(2, 1'b1);
    // Full buffer with drops, then full buffer with last on a dropped sample, then exactly full.
    for (int i = 0; i < MAX_LEN + 2; i++) add_sample($urandom, i == MAX_LEN + 1);
    for (int i = 0; i < MAX_LEN + 1; i++) add_sample(rand_sample(2), i == MAX_LEN);
    for (int i = 0; i < MAX_LEN; i++) add_sample(rand_sample(1), i == MAX_LEN - 1);
    wait_drained();

    // Random vectors in three phases of input and output idling, the last with none.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 36 : 0;
      for (int v = 0; v < 5; v++) begin
        len = $urandom_range(1, 12);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) add_sample(rand_sample(mode), i == len - 1);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_fits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
